// File: hw/rtl/crcmd_pkg.sv
// Package for the CRC-32C message deframer: verdict codes, register
// indexes, widths and the CRC-32C byte table function. No dependencies.
package crcmd_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned LenW     = 33;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] CrcPoly  = 32'h82F63B78;
  localparam logic [31:0] CrcInit  = 32'hFFFFFFFF;
  localparam logic [7:0]  OpCount  = 8'd12;

  typedef enum logic [2:0] {
    VERD_OK         = 3'd0,
    VERD_INCOMPLETE = 3'd1,
    VERD_UNKNOWN_OP = 3'd2,
    VERD_BAD_LEN    = 3'd3,
    VERD_BAD_DIGEST = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    REG_OP_LOW  = 3'd0,
    REG_OP_HIGH = 3'd1,
    REG_MAX_LEN = 3'd2,
    REG_HDR_DG  = 3'd3,
    REG_DAT_DG  = 3'd4
  } reg_idx_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [47:0] op_low;
    logic [47:0] op_high;
    logic [31:0] max_len;
    logic        hdr_dg;
    logic        dat_dg;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  op_code;
    logic [7:0]  stat_code;
    logic [15:0] req_id;
    logic [31:0] body_length;
    logic [7:0]  op_header_length;
    logic [32:0] message_length;
  } result_t;

  // Reflected CRC-32C table entry (constant logic)
  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crcmd_if.sv
// Valid/ready channel interface carrying one word of payload type.
// Depends on nothing; payload width given as a parameter.
interface crcmd_if #(parameter int unsigned W = 9) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/crcmd_front.sv
// Front end: accepts input words and queues them for the back end.
// Depends on crcmd_pkg.
module crcmd_front
  import crcmd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [DataW:0]  in_word,
  output logic            q_valid,
  input  logic            q_ready,
  output logic [DataW:0]  q_word
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DataW:0] mem_r [Depth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign in_ready = (cnt_r != (AW+1)'(Depth));
  assign q_valid  = (cnt_r != '0);
  assign q_word   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// File: hw/rtl/crcmd_back.sv
// Back end: parses the header, runs CRC-32C, checks digests and holds the
// result word in an output register. Depends on crcmd_pkg.
module crcmd_back
  import crcmd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  logic [DataW:0]  q_word,
  output logic            out_valid,
  input  logic            out_ready,
  output result_t         out_res
);
  logic [32:0] pos_r, pos_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] dig_r, dig_nxt;
  logic        hbad_r, hbad_nxt, dbad_r, dbad_nxt, sent_r, sent_nxt;
  logic        ov_r;
  result_t     res_r;

  logic [7:0]  b;
  logic        last, take;
  logic [63:0] hdr_cur;
  logic [7:0]  op;
  logic [7:0]  ohs;
  logic [31:0] blen;
  logic [33:0] hdr_end, bstart, body_end, total;
  logic [31:0] crc_step;
  logic [33:0] p, q;
  logic [1:0]  dsh;
  logic        emit;
  verdict_t    verd;
  logic        ok;

  assign b     = q_word[DataW-1:0];
  assign last  = q_word[DataW];
  assign q_ready = !ov_r || out_ready;
  assign take  = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  // Geometry from the header as it stands after this byte
  always_comb begin
    hdr_cur = hdr_r;
    if (take && !sent_r && pos_r < 33'd8) begin
      hdr_cur[8*pos_r[2:0] +: 8] = b;
    end
    op    = hdr_cur[7:0];
    ohs   = '0;
    case (op)
      8'd1:  ohs = cfg.op_low[7:0];
      8'd2:  ohs = cfg.op_low[15:8];
      8'd3:  ohs = cfg.op_low[23:16];
      8'd4:  ohs = cfg.op_low[31:24];
      8'd5:  ohs = cfg.op_low[39:32];
      8'd6:  ohs = cfg.op_low[47:40];
      8'd7:  ohs = cfg.op_high[7:0];
      8'd8:  ohs = cfg.op_high[15:8];
      8'd9:  ohs = cfg.op_high[23:16];
      8'd10: ohs = cfg.op_high[31:24];
      8'd11: ohs = cfg.op_high[39:32];
      8'd12: ohs = cfg.op_high[47:40];
      default: ohs = '0;
    endcase
    blen       = hdr_cur[63:32];
    hdr_end    = 34'd8 + 34'(ohs);
    bstart     = hdr_end + (cfg.hdr_dg ? 34'd4 : 34'd0);
    body_end   = bstart + 34'(blen);
    total      = body_end + (cfg.dat_dg ? 34'd4 : 34'd0);
  end

  // Per-byte step
  always_comb begin
    pos_nxt = pos_r; hdr_nxt = hdr_r; crc_nxt = crc_r; dig_nxt = dig_r;
    hbad_nxt = hbad_r; dbad_nxt = dbad_r; sent_nxt = sent_r;
    emit = 1'b0; verd = VERD_OK; ok = 1'b0;
    p = {1'b0, pos_r};
    q = p + 34'd1;
    crc_step = crc_entry(crc_r[7:0] ^ b) ^ (crc_r >> 8);
    dsh = '0;
    if (take) begin
      if (!sent_r) begin
        if (p < 34'd8) begin
          hdr_nxt[8*pos_r[2:0] +: 8] = b;
          crc_nxt = crc_step;
        end else if (p < hdr_end || (p >= bstart && p < body_end)) begin
          crc_nxt = crc_step;
        end else begin
          dsh = (p < bstart) ? 2'(p - hdr_end) : 2'(p - body_end);
          dig_nxt[8*dsh +: 8] = dig_r[8*dsh +: 8] | b;
        end
        pos_nxt = q[32:0];
        if (q == 34'd8) begin
          // header checks on the freshly completed header
          if (!(hdr_nxt[7:0] >= 8'd1 && hdr_nxt[7:0] <= OpCount)) begin
            emit = 1'b1; verd = VERD_UNKNOWN_OP;
          end else if (hdr_nxt[63:32] > cfg.max_len ||
                       (hdr_nxt[63:32] != 32'd0 && hdr_nxt[7:0] != 8'd2 &&
                        hdr_nxt[7:0] != 8'd5 && hdr_nxt[7:0] != 8'd8)) begin
            emit = 1'b1; verd = VERD_BAD_LEN;
          end
        end
      end
      // region boundaries use the header as completed by this byte
      if (!sent_r && !emit && q >= 34'd8) begin
        if (q == bstart) begin
          if (cfg.hdr_dg) begin
            hbad_nxt = dig_nxt != ~crc_nxt;
          end
          dig_nxt = '0;
          crc_nxt = CrcInit;
        end
        if (q == total) begin
          if (cfg.dat_dg) begin
            dbad_nxt = dig_nxt != ~crc_nxt;
          end
          emit = 1'b1;
          if (hbad_nxt || dbad_nxt) begin
            verd = VERD_BAD_DIGEST;
          end else begin
            verd = VERD_OK; ok = 1'b1;
          end
        end
      end
      if (emit) begin
        sent_nxt = 1'b1;
      end
      if (last && !sent_r && !emit) begin
        emit = 1'b1; verd = VERD_INCOMPLETE; ok = 1'b0;
      end
    end
  end

  // Message state; buffer end rearms everything
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      pos_r <= '0; hdr_r <= '0; crc_r <= CrcInit; dig_r <= '0;
      hbad_r <= 1'b0; dbad_r <= 1'b0; sent_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; hdr_r <= hdr_nxt; crc_r <= crc_nxt; dig_r <= dig_nxt;
      hbad_r <= hbad_nxt; dbad_r <= dbad_nxt; sent_r <= sent_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.verdict <= verd;
      if (q >= 34'd8) begin
        res_r.op_code     <= hdr_nxt[7:0];
        res_r.stat_code   <= hdr_nxt[15:8];
        res_r.req_id      <= hdr_nxt[31:16];
        res_r.body_length <= hdr_nxt[63:32];
        res_r.op_header_length <= ohs;
      end else begin
        res_r.op_code <= '0; res_r.stat_code <= '0; res_r.req_id <= '0;
        res_r.body_length <= '0; res_r.op_header_length <= '0;
      end
      res_r.message_length <= ok ? total[32:0] : '0;
    end
  end
endmodule

// File: hw/rtl/crc32c_message_deframer_top.sv
// CRC-32C message deframer, top level: channels, APB registers, front and
// back ends. Depends on crcmd_pkg, crcmd_if, crcmd_front, crcmd_back.
//
// Usage: send the bytes of one receive buffer on in_ (data_byte, last_byte).
// One verdict word per buffer leaves on out_: early on unknown op or bad
// length after the eighth byte, at message end (ok or bad digest), or
// "incomplete" on last_byte when no verdict was given. Later bytes up to
// last_byte are dropped. last_byte rearms the deframer.
// Throughput: one byte per cycle while no verdict is stalled in the output
// register; the CRC table step and position compare are combinational.
// A byte is written into the 4-word queue, read from it by the back end
// and its verdict is registered in the output register that drives out_.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// verdict, clears the configuration registers to zero and rearms the
// deframer. When the receiver stalls the verdict holds in the output
// register; the queue keeps taking bytes until it is full, then in_ready
// drops.
// Registers at byte address 8*i, 64-bit data: op sizes low, op sizes high,
// max body length, header digest enable, data digest enable.
module crc32c_message_deframer_top
  import crcmd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  crcmd_if.sink       in_ch,
  crcmd_if.source     out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  cfg_t        cfg_r;
  logic        q_valid, q_ready, wr;
  logic [DataW:0] q_word;
  result_t     res;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[5:3]);
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr && cfg_paddr[2:0] == 3'd0) begin
      case (idx)
        REG_OP_LOW:  cfg_r.op_low  <= cfg_pwdata[47:0];
        REG_OP_HIGH: cfg_r.op_high <= cfg_pwdata[47:0];
        REG_MAX_LEN: cfg_r.max_len <= cfg_pwdata[31:0];
        REG_HDR_DG:  cfg_r.hdr_dg  <= cfg_pwdata[0];
        REG_DAT_DG:  cfg_r.dat_dg  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      REG_OP_LOW:  cfg_prdata = {16'd0, cfg_r.op_low};
      REG_OP_HIGH: cfg_prdata = {16'd0, cfg_r.op_high};
      REG_MAX_LEN: cfg_prdata = {32'd0, cfg_r.max_len};
      REG_HDR_DG:  cfg_prdata = {63'd0, cfg_r.hdr_dg};
      REG_DAT_DG:  cfg_prdata = {63'd0, cfg_r.dat_dg};
      default:     cfg_prdata = '0;
    endcase
  end

  crcmd_front #(.Depth(Depth)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.data),
    .q_valid, .q_ready, .q_word
  );

  crcmd_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_valid, .q_ready, .q_word,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.data = res;

`ifndef SYNTH
  // A stalled verdict word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("verdict changed while stalled");
  // Only ok carries a message length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res.verdict != VERD_OK |-> res.message_length == '0)
    else $error("length on a failed verdict");
  // Back end takes nothing while a verdict is stuck
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !q_ready)
    else $error("back end ran during stall");
`endif
endmodule

// File: tb/crcmd_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the CRC-32C message deframer testbench: a byte-level
// predictor of the verdict words and a queue of pending verdicts.
// Depends on crcmd_pkg.
package crcmd_tb_pkg;
  import crcmd_pkg::*;

  class verdict_scoreboard;
    // register copy
    logic [47:0] op_low, op_high;
    logic [31:0] max_len;
    bit          hdr_dg, dat_dg;
    // deframer state
    logic [32:0] pos;
    logic [63:0] hdr;
    logic [31:0] crc, digest;
    bit          hdr_bad, dat_bad, sent;
    logic [31:0] crc_tab[256];
    result_t     pending[$];
    int          errors;

    function new();
      logic [31:0] c;
      for (int i = 0; i < 256; i++) begin
        c = i;
        for (int k = 0; k < 8; k++) c = c[0] ? (32'h82F63B78 ^ (c >> 1)) : (c >> 1);
        crc_tab[i] = c;
      end
      op_low = 0; op_high = 0; max_len = 0; hdr_dg = 0; dat_dg = 0;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      pos = 0; hdr = 0; crc = '1; digest = 0;
      hdr_bad = 0; dat_bad = 0; sent = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_OP_LOW:  op_low = v[47:0];
        REG_OP_HIGH: op_high = v[47:0];
        REG_MAX_LEN: max_len = v[31:0];
        REG_HDR_DG:  hdr_dg = v[0];
        REG_DAT_DG:  dat_dg = v[0];
        default: ;
      endcase
    endfunction

    function void crc_step(logic [7:0] b);
      crc = crc_tab[crc[7:0] ^ b] ^ (crc >> 8);
    endfunction

    function logic [7:0] oh_len();
      logic [7:0] op;
      op = hdr[7:0];
      if (op < 1 || op > 12) return 0;
      if (op <= 6) return 8'(op_low >> (8 * (op - 1)));
      return 8'(op_high >> (8 * (op - 7)));
    endfunction

    function logic [33:0] hdr_end();
      return 34'd8 + oh_len();
    endfunction

    function logic [33:0] body_base();
      return hdr_end() + (hdr_dg ? 4 : 0);
    endfunction

    function logic [33:0] total_len();
      return body_base() + hdr[63:32] + (dat_dg ? 4 : 0);
    endfunction

    function void give(verdict_t v);
      result_t r;
      bit seen;
      logic [7:0] op;
      seen = pos >= 8;
      op = hdr[7:0];
      r = '0;
      r.verdict = v;
      if (seen) begin
        r.op_code = hdr[7:0];
        r.stat_code = hdr[15:8];
        r.req_id = hdr[31:16];
        r.body_length = hdr[63:32];
        if (op >= 1 && op <= 12) r.op_header_length = oh_len();
      end
      if (v == VERD_OK) r.message_length = 33'(total_len());
      pending = {pending, r};
      sent = 1;
    endfunction

    // predict the verdict caused by one accepted byte
    function void note_byte(logic [7:0] b, bit last);
      logic [33:0] p, q, bs, blen;
      logic [7:0] op;
      if (!sent) begin
        p = 34'(pos);
        if (p < 8) begin
          hdr = hdr | (64'(b) << (8 * p));
          crc_step(b);
        end else begin
          bs = body_base();
          blen = 34'(hdr[63:32]);
          if (p < hdr_end()) crc_step(b);
          else if (p < bs) digest |= 32'(b) << (8 * ((p - hdr_end()) & 3));
          else if (p < bs + blen) crc_step(b);
          else digest |= 32'(b) << (8 * ((p - bs - blen) & 3));
        end
        q = p + 1;
        pos = q[32:0];
        op = hdr[7:0];
        if (q == 8) begin
          if (op < 1 || op > 12) give(VERD_UNKNOWN_OP);
          else if (hdr[63:32] > max_len ||
                   (hdr[63:32] != 0 && op != 2 && op != 5 && op != 8))
            give(VERD_BAD_LEN);
        end
        if (!sent && q >= 8) begin
          if (q == body_base()) begin
            if (hdr_dg) hdr_bad = digest != ~crc;
            digest = 0;
            crc = '1;
          end
          if (q == total_len()) begin
            if (dat_dg) dat_bad = digest != ~crc;
            give((hdr_bad || dat_bad) ? VERD_BAD_DIGEST : VERD_OK);
          end
        end
      end
      if (last) begin
        if (!sent) give(VERD_INCOMPLETE);
        rearm();
      end
    endfunction

    function void check_verdict(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected verdict word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.verdict !== e.verdict) begin
        $error("verdict: expected %0d got %0d", e.verdict, got.verdict); errors++;
      end
      if (got.op_code !== e.op_code) begin
        $error("op_code: expected %h got %h", e.op_code, got.op_code); errors++;
      end
      if (got.stat_code !== e.stat_code) begin
        $error("stat_code: expected %h got %h", e.stat_code, got.stat_code);
        errors++;
      end
      if (got.req_id !== e.req_id) begin
        $error("req_id: expected %h got %h", e.req_id, got.req_id);
        errors++;
      end
      if (got.body_length !== e.body_length) begin
        $error("body_length: expected %h got %h", e.body_length, got.body_length);
        errors++;
      end
      if (got.op_header_length !== e.op_header_length) begin
        $error("op_header_length: expected %h got %h", e.op_header_length,
               got.op_header_length);
        errors++;
      end
      if (got.message_length !== e.message_length) begin
        $error("message_length: expected %h got %h", e.message_length,
               got.message_length);
        errors++;
      end
    endfunction
  endclass
endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the CRC-32C message deframer testbench: clock, reset, APB writes,
// byte driver, verdict monitor and watchdog. Depends on crcmd_pkg,
// crcmd_if, crcmd_tb_pkg and crc32c_message_deframer_top.
module testbench;
  import crcmd_pkg::*;
  import crcmd_tb_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  crcmd_if #(.W(9)) in_ch (clk);
  crcmd_if #(.W($bits(result_t))) out_ch (clk);

  crc32c_message_deframer_top dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  verdict_scoreboard sb = new();
  int  idle_cycles;
  bit  hold_off;       // long receiver hold-off requested
  logic [7:0] msg[$];  // bytes of the buffer being built
  // content-aware CRC helper for building good digests
  logic [31:0] crc_tab[256];

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  initial begin
    rst_n = 1'b0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_ch.valid = 0; in_ch.data = '0;
    out_ch.ready = 0;
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // verdict monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_verdict(result_t'(out_ch.data));
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 6'(8 * idx); cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send_byte(logic [7:0] b, bit last, bit gaps);
    int w;
    w = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0) : 0;
    if (w > 0) begin
      @(negedge clk);
      in_ch.valid <= 0;
      repeat (w - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1; in_ch.data <= {last, b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_buffer(bit gaps);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, gaps);
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] crc_of(int from, int upto);
    logic [31:0] c;
    c = '1;
    for (int i = from; i < upto; i++) c = crc_tab[c[7:0] ^ msg[i]] ^ (c >> 8);
    return ~c;
  endfunction

  function automatic void put(logic [7:0] v);
    msg = {msg, v};
  endfunction

  function automatic void push32(logic [31:0] v);
    for (int i = 0; i < 4; i++) put(v[8*i +: 8]);
  endfunction

  // build a buffer: op, body length; mode 0 good, 1 corrupt digest,
  // 2 truncated, 3 trailing bytes
  function automatic void build(logic [7:0] op, logic [31:0] blen, int mode);
    int hs, bs, ohs;
    msg.delete();
    ohs = (op >= 1 && op <= 12) ? ((op <= 6) ? 8'(sb.op_low >> (8 * (op - 1)))
                                            : 8'(sb.op_high >> (8 * (op - 7)))) : 0;
    put(op);
    put(8'($urandom));
    put(8'($urandom)); put(8'($urandom));
    push32(blen);
    for (int i = 0; i < ohs; i++) put(8'($urandom));
    hs = msg.size();
    if (sb.hdr_dg) push32(crc_of(0, hs) ^ ((mode == 1 && $urandom_range(0, 1))
                                           ? 32'(1 << $urandom_range(0, 31)) : 0));
    bs = msg.size();
    for (int i = 0; i < int'(blen) && i < 64; i++) put(8'($urandom));
    if (sb.dat_dg) push32(crc_of(bs, msg.size()) ^ (mode == 1 ? 32'h1 << $urandom_range(0, 31)
                                                              : 0));
    if (mode == 2 && msg.size() > 1) begin
      int keep;
      keep = $urandom_range(1, msg.size() - 1);
      while (msg.size() > keep) void'(msg.pop_back());
    end
    if (mode == 3) repeat ($urandom_range(1, 6)) put(8'($urandom));
  endfunction

  task automatic set_regs(logic [47:0] lo, logic [47:0] hi, logic [31:0] ml, bit hd, bit dd);
    apb_write(REG_OP_LOW, lo);
    apb_write(REG_OP_HIGH, hi);
    apb_write(REG_MAX_LEN, ml);
    apb_write(REG_HDR_DG, hd);
    apb_write(REG_DAT_DG, dd);
  endtask

  initial begin
    int items;
    logic [7:0] op;
    logic [31:0] blen;
    logic [31:0] c;
    idle_cycles = 0; hold_off = 0; items = 0;
    for (int i = 0; i < 256; i++) begin
      c = i;
      for (int k = 0; k < 8; k++) c = c[0] ? (32'h82F63B78 ^ (c >> 1)) : (c >> 1);
      crc_tab[i] = c;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: registers at reset values, then small op headers with digests
    msg = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer(0);                               // unknown op zero
    msg = '{8'h05, 8'h01, 8'h02};
    send_buffer(0);                               // incomplete header
    drain();
    set_regs(48'h030201000402, 48'h010002000300, 32'd6, 1, 1);
    build(8'd2, 6, 0); send_buffer(0);            // ok with both digests
    build(8'd5, 7, 0); send_buffer(0);            // bad length (over max)
    build(8'd1, 1, 0); send_buffer(0);            // nonzero body on op 1
    build(8'd13, 0, 0); send_buffer(0);           // unknown op
    build(8'd8, 3, 1); send_buffer(0);            // bad digest
    build(8'd8, 3, 2); send_buffer(0);            // truncated
    build(8'd12, 0, 3); send_buffer(0);           // trailing bytes
    drain();
    set_regs('1, '1, '1, 0, 0);
    build(8'hFF, 32'hFFFF_FFFF, 0); send_buffer(0);
    build(8'd2, 32'hFFFF_FFFF, 2); send_buffer(0); // long body cut short
    drain();

    // random phases with varied register settings
    for (int ph = 0; ph < 6; ph++) begin
      set_regs({6{8'($urandom_range(0, 6))}} ^ 48'($urandom) & 48'h030303030303,
               48'($urandom) & 48'h070707070707, $urandom_range(0, 40),
               $urandom_range(0, 1), $urandom_range(0, 1));
      for (int n = 0; n < 7; n++) begin
        if (ph == 2 && n == 2) hold_off = 1;
        op = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
        blen = (op == 2 || op == 5 || op == 8) ? $urandom_range(0, 20)
             : ($urandom_range(0, 7) == 0 ? $urandom_range(1, 4) : 0);
        if ($urandom_range(0, 15) == 0) begin
          msg.delete();
          repeat ($urandom_range(1, 20)) put(8'($urandom));
        end else
          build(op, blen, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
        send_buffer(ph != 4);
        items += msg.size();
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
